/* rtl/frame_rotate_to_direction_core_macros.svh */
`ifndef FRAME_ROTATE_TO_DIRECTION_CORE_MACROS_SVH
`define FRAME_ROTATE_TO_DIRECTION_CORE_MACROS_SVH

// Check on every rising clock edge, reset included.
`define FRD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only.
`define FRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/frd_pkg.sv */
package frd_pkg;

  localparam int WORD_W     = 32;
  localparam int UNIT_W     = 32;
  localparam int UNIT_SHIFT = 30;
  localparam int NORM_W     = 31;
  localparam int SQRT_STG   = 32;
  localparam int DIV_STG    = 31;
  localparam int UNIT_LAT   = SQRT_STG + DIV_STG + 8;
  localparam int PIPE_LAT   = 2 * UNIT_LAT + 8;
  localparam int PROD_W     = 64;
  localparam int PROJ_W     = 36;
  localparam int TERM_W     = UNIT_W + PROJ_W;
  localparam int RND_W      = 72;

  // Cyclic neighbors for cross products.
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    word_t from_dir_x;
    word_t from_dir_y;
    word_t from_dir_z;
    word_t to_dir_x;
    word_t to_dir_y;
    word_t to_dir_z;
    word_t frame_u_x;
    word_t frame_u_y;
    word_t frame_u_z;
    word_t frame_v_x;
    word_t frame_v_y;
    word_t frame_v_z;
  } in_t;

  typedef struct packed {
    word_t out_u_x;
    word_t out_u_y;
    word_t out_u_z;
    word_t out_v_x;
    word_t out_v_y;
    word_t out_v_z;
    word_t out_from_x;
    word_t out_from_y;
    word_t out_from_z;
    logic  rotated;
  } out_t;

  // Drop UNIT_SHIFT fraction bits, rounding half away from zero.
  function automatic logic signed [RND_W-1:0] rnd_shr(input logic signed [RND_W-1:0] v);
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] m;
    mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
    m = (mag + (RND_W'(1) << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
    rnd_shr = v[RND_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic word_t sat_word(input logic signed [RND_W-1:0] v);
    logic [RND_W-WORD_W:0] upper;
    upper = v[RND_W-1:WORD_W-1];
    if ((&upper) | ~(|upper)) begin
      sat_word = v[WORD_W-1:0];
    end else if (v[RND_W-1]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* rtl/frd_unitize.sv */
module frd_unitize #(
  parameter int IN_W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [IN_W-1:0] vec_i [3],
  output logic                   out_valid,
  output frd_pkg::unit_t         vec_o [3]
);

  localparam int PW = $clog2(IN_W);
  localparam int NW = frd_pkg::NORM_W;
  localparam int SS = frd_pkg::SQRT_STG;
  localparam int DS = frd_pkg::DIV_STG;
  localparam int SH = frd_pkg::UNIT_SHIFT;
  localparam int SW = 2 * NW + 2;
  localparam int DW = NW + SH + 1;

  // front: magnitude, max, leading one, normalize, square, sum
  logic            v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [IN_W-1:0] mag1_r [3];
  logic [IN_W-1:0] mag2_r [3];
  logic [IN_W-1:0] mag3_r [3];
  logic [2:0]      neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [IN_W-1:0] top2_r;
  logic [IN_W-1:0] top_nxt;
  logic [PW-1:0]   pos3_r;
  logic [PW-1:0]   pos_nxt;
  logic            z3_r, z4_r, z5_r;
  logic [NW-1:0]   nm4_r [3];
  logic [NW-1:0]   nm_nxt [3];
  logic [NW-1:0]   nm5_r [3];
  logic [2*NW-1:0] sq5_r [3];

  // square root stages
  logic [SW-1:0]   srem_r  [SS+1];
  logic [SS-1:0]   sroot_r [SS+1];
  logic [NW-1:0]   snm_r   [SS+1][3];
  logic [2:0]      sneg_r  [SS+1];
  logic            sz_r    [SS+1];
  logic            sv_r    [SS+1];

  // divider stages
  logic [DW-1:0]   drem_r [DS+1][3];
  logic [NW-1:0]   dq_r   [DS+1][3];
  logic [SS-1:0]   dn_r   [DS+1];
  logic [2:0]      dneg_r [DS+1];
  logic            dz_r   [DS+1];
  logic            dv_r   [DS+1];

  logic            fv_r;
  frd_pkg::unit_t  vo_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      sv_r[0] <= 1'b0;
      dv_r[0] <= 1'b0;
      fv_r  <= 1'b0;
    end else begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      sv_r[0] <= v5_r;
      dv_r[0] <= sv_r[SS];
      fv_r  <= dv_r[DS];
    end
  end

  always_comb begin
    top_nxt = (mag1_r[0] > mag1_r[1]) ? mag1_r[0] : mag1_r[1];
    top_nxt = (top_nxt > mag1_r[2]) ? top_nxt : mag1_r[2];
  end

  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (top2_r[b]) pos_nxt = PW'(b);
    end
  end

  // bring the largest magnitude into [2^30, 2^31)
  always_comb begin
    logic [IN_W-1:0] shifted;
    for (int i = 0; i < 3; i++) begin
      if (pos3_r >= PW'(SH)) begin
        shifted = mag3_r[i] >> (pos3_r - PW'(SH));
      end else begin
        shifted = mag3_r[i] << (PW'(SH) - pos3_r);
      end
      nm_nxt[i] = shifted[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= vec_i[i][IN_W-1];
      mag1_r[i] <= vec_i[i][IN_W-1] ? IN_W'(-vec_i[i]) : IN_W'(vec_i[i]);
      mag2_r[i] <= mag1_r[i];
      mag3_r[i] <= mag2_r[i];
      nm4_r[i]  <= nm_nxt[i];
      nm5_r[i]  <= nm4_r[i];
      sq5_r[i]  <= (2*NW)'(nm4_r[i]) * (2*NW)'(nm4_r[i]);
      snm_r[0][i] <= nm5_r[i];
    end
    neg2_r  <= neg1_r;
    neg3_r  <= neg2_r;
    neg4_r  <= neg3_r;
    neg5_r  <= neg4_r;
    top2_r  <= top_nxt;
    pos3_r  <= pos_nxt;
    z3_r    <= (top2_r == '0);
    z4_r    <= z3_r;
    z5_r    <= z4_r;
    srem_r[0]  <= SW'(sq5_r[0]) + SW'(sq5_r[1]) + SW'(sq5_r[2]);
    sroot_r[0] <= '0;
    sneg_r[0]  <= neg5_r;
    sz_r[0]    <= z5_r;
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam int BT = SS - 1 - k;
    logic [SW+1:0] trial;
    logic          ge;
    assign trial = ((SW+2)'(sroot_r[k]) << (BT + 1)) + ((SW+2)'(1) << (2 * BT));
    assign ge    = (SW+2)'(srem_r[k]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else        sv_r[k+1] <= sv_r[k];
    end

    always_ff @(posedge clk) begin
      srem_r[k+1]  <= ge ? SW'((SW+2)'(srem_r[k]) - trial) : srem_r[k];
      sroot_r[k+1] <= ge ? (sroot_r[k] | (SS'(1) << BT)) : sroot_r[k];
      snm_r[k+1]   <= snm_r[k];
      sneg_r[k+1]  <= sneg_r[k];
      sz_r[k+1]    <= sz_r[k];
    end
  end

  // dividend with half the divisor added for rounding
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      drem_r[0][i] <= (DW'(snm_r[SS][i]) << SH) + DW'(sroot_r[SS] >> 1);
      dq_r[0][i]   <= '0;
    end
    dn_r[0]   <= sroot_r[SS];
    dneg_r[0] <= sneg_r[SS];
    dz_r[0]   <= sz_r[SS];
  end

  // one quotient bit per stage
  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int BT = DS - 1 - j;
    logic [DW:0]   dsub;
    logic [DW-1:0] rem_nxt [3];
    logic [NW-1:0] q_nxt [3];
    assign dsub = (DW+1)'(dn_r[j]) << BT;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if ((DW+1)'(drem_r[j][i]) >= dsub) begin
          rem_nxt[i] = DW'((DW+1)'(drem_r[j][i]) - dsub);
          q_nxt[i]   = dq_r[j][i] | (NW'(1) << BT);
        end else begin
          rem_nxt[i] = drem_r[j][i];
          q_nxt[i]   = dq_r[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else        dv_r[j+1] <= dv_r[j];
    end

    always_ff @(posedge clk) begin
      drem_r[j+1] <= rem_nxt;
      dq_r[j+1]   <= q_nxt;
      dn_r[j+1]   <= dn_r[j];
      dneg_r[j+1] <= dneg_r[j];
      dz_r[j+1]   <= dz_r[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dz_r[DS]) begin
        vo_r[i] <= '0;
      end else if (dneg_r[DS][i]) begin
        vo_r[i] <= -$signed({1'b0, dq_r[DS][i]});
      end else begin
        vo_r[i] <= $signed({1'b0, dq_r[DS][i]});
      end
    end
  end

  assign out_valid = fv_r;
  assign vec_o     = vo_r;

endmodule

/* rtl/frame_rotate_to_direction_core.sv */
// Rotates two frame vectors u, v by the minimal rotation that carries direction a onto
// direction b, all signed Q16.16. One item is taken per clock while busy is low (busy is
// high only during and right after reset); every result appears on out_item for a single
// cycle with out_valid, in order. The pipeline is two vector normalizers in series (a and b
// side by side, then the axis), each 71 stages long: five front stages, a 32-stage square
// root, a 31-stage divider and three hand-off registers; eight stages of multiply and round
// complete it, the axis cross product between the two normalizers and the rest after them.
// A parallel, antiparallel or zero direction passes the item through with rotated low.
module frame_rotate_to_direction_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  frd_pkg::in_t  in_item,
  output logic          out_valid,
  output frd_pkg::out_t out_item
);

  localparam int UL = frd_pkg::UNIT_LAT;
  localparam int PD = frd_pkg::PROD_W;
  localparam int PJ = frd_pkg::PROJ_W;
  localparam int TW = frd_pkg::TERM_W;
  localparam int RW = frd_pkg::RND_W;
  localparam int UW = frd_pkg::UNIT_W;

  typedef struct packed {
    frd_pkg::in_t          item;
    logic [2:0][UW-1:0]    a;
    logic [2:0][UW-1:0]    b;
  } side_t;

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  frd_pkg::word_t fa [3];
  frd_pkg::word_t fb [3];
  frd_pkg::unit_t ua [3];
  frd_pkg::unit_t ub [3];
  logic           ua_v, ub_v, ab_v;

  assign fa = '{in_item.from_dir_x, in_item.from_dir_y, in_item.from_dir_z};
  assign fb = '{in_item.to_dir_x, in_item.to_dir_y, in_item.to_dir_z};

  frd_unitize #(.IN_W(frd_pkg::WORD_W)) u_unit_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .vec_i     (fa),
    .out_valid (ua_v),
    .vec_o     (ua)
  );

  frd_unitize #(.IN_W(frd_pkg::WORD_W)) u_unit_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .vec_i     (fb),
    .out_valid (ub_v),
    .vec_o     (ub)
  );

  assign ab_v = ua_v & ub_v;

  // hold the raw item alongside the normalizers
  frd_pkg::in_t idly_r [UL];

  always_ff @(posedge clk) begin
    idly_r[0] <= in_item;
    for (int k = 1; k < UL; k++) idly_r[k] <= idly_r[k-1];
  end

  // axis = a x b
  logic               t1_v_r, t2_v_r;
  logic signed [PD-1:0] t1_p_r [6];
  logic signed [PD-1:0] t2_c_r [3];
  side_t              t1_s_r, t2_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
    end else begin
      t1_v_r <= ab_v;
      t2_v_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t1_p_r[2*i]   <= PD'(ua[frd_pkg::NXT[i]]) * PD'(ub[frd_pkg::PRV[i]]);
      t1_p_r[2*i+1] <= PD'(ua[frd_pkg::PRV[i]]) * PD'(ub[frd_pkg::NXT[i]]);
      t1_s_r.a[i]   <= ua[i];
      t1_s_r.b[i]   <= ub[i];
      t2_c_r[i]     <= t1_p_r[2*i] - t1_p_r[2*i+1];
    end
    t1_s_r.item <= idly_r[UL-1];
    t2_s_r      <= t1_s_r;
  end

  frd_pkg::unit_t un [3];
  logic           un_v;

  frd_unitize #(.IN_W(PD)) u_unit_n (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t2_v_r),
    .vec_i     (t2_c_r),
    .out_valid (un_v),
    .vec_o     (un)
  );

  side_t sdly_r [UL];

  always_ff @(posedge clk) begin
    sdly_r[0] <= t2_s_r;
    for (int k = 1; k < UL; k++) sdly_r[k] <= sdly_r[k-1];
  end

  // helper axes a x n and b x n
  logic                 r1_v_r, r2_v_r;
  logic signed [PD-1:0] r1_pa_r [6];
  logic signed [PD-1:0] r1_pb_r [6];
  frd_pkg::unit_t       r1_n_r [3];
  frd_pkg::unit_t       r2_n_r [3];
  frd_pkg::unit_t       r2_an_r [3];
  frd_pkg::unit_t       r2_bn_r [3];
  side_t                r1_s_r, r2_s_r;
  logic                 r1_deg_r, r2_deg_r;
  side_t                s_in;

  assign s_in = sdly_r[UL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
    end else begin
      r1_v_r <= un_v;
      r2_v_r <= r1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      r1_pa_r[2*i]   <= PD'($signed(s_in.a[frd_pkg::NXT[i]])) * PD'(un[frd_pkg::PRV[i]]);
      r1_pa_r[2*i+1] <= PD'($signed(s_in.a[frd_pkg::PRV[i]])) * PD'(un[frd_pkg::NXT[i]]);
      r1_pb_r[2*i]   <= PD'($signed(s_in.b[frd_pkg::NXT[i]])) * PD'(un[frd_pkg::PRV[i]]);
      r1_pb_r[2*i+1] <= PD'($signed(s_in.b[frd_pkg::PRV[i]])) * PD'(un[frd_pkg::NXT[i]]);
      r1_n_r[i]      <= un[i];
      r2_n_r[i]      <= r1_n_r[i];
      r2_an_r[i]     <= UW'(frd_pkg::rnd_shr(RW'(r1_pa_r[2*i] - r1_pa_r[2*i+1])));
      r2_bn_r[i]     <= UW'(frd_pkg::rnd_shr(RW'(r1_pb_r[2*i] - r1_pb_r[2*i+1])));
    end
    // a zero axis means parallel, antiparallel or zero inputs
    r1_deg_r <= (un[0] == '0) && (un[1] == '0) && (un[2] == '0);
    r2_deg_r <= r1_deg_r;
    r1_s_r   <= s_in;
    r2_s_r   <= r1_s_r;
  end

  // projections onto a, n and a x n
  frd_pkg::word_t       fx [2][3];
  frd_pkg::unit_t       pax [3][3];
  logic                 d1_v_r, d2_v_r;
  logic signed [PD-1:0] d1_p_r [2][3][3];
  logic signed [PJ-1:0] d2_pr_r [2][3];
  frd_pkg::unit_t       d1_b_r [3];
  frd_pkg::unit_t       d1_n_r [3];
  frd_pkg::unit_t       d1_bn_r [3];
  frd_pkg::unit_t       d2_b_r [3];
  frd_pkg::unit_t       d2_n_r [3];
  frd_pkg::unit_t       d2_bn_r [3];
  frd_pkg::in_t         d1_item_r, d2_item_r;
  logic                 d1_deg_r, d2_deg_r;

  assign fx[0] = '{r2_s_r.item.frame_u_x, r2_s_r.item.frame_u_y, r2_s_r.item.frame_u_z};
  assign fx[1] = '{r2_s_r.item.frame_v_x, r2_s_r.item.frame_v_y, r2_s_r.item.frame_v_z};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pax[0][c] = $signed(r2_s_r.a[c]);
      pax[1][c] = r2_n_r[c];
      pax[2][c] = r2_an_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else begin
      d1_v_r <= r2_v_r;
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 2; w++) begin
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          d1_p_r[w][p][c] <= PD'(fx[w][c]) * PD'(pax[p][c]);
        end
        d2_pr_r[w][p] <= PJ'(frd_pkg::rnd_shr(RW'(d1_p_r[w][p][0]) + RW'(d1_p_r[w][p][1])
                                             + RW'(d1_p_r[w][p][2])));
      end
    end
    for (int c = 0; c < 3; c++) begin
      d1_b_r[c]  <= $signed(r2_s_r.b[c]);
      d1_n_r[c]  <= r2_n_r[c];
      d1_bn_r[c] <= r2_bn_r[c];
      d2_b_r[c]  <= d1_b_r[c];
      d2_n_r[c]  <= d1_n_r[c];
      d2_bn_r[c] <= d1_bn_r[c];
    end
    d1_item_r <= r2_s_r.item;
    d2_item_r <= d1_item_r;
    d1_deg_r  <= r2_deg_r;
    d2_deg_r  <= d1_deg_r;
  end

  // rebuild: b*pa + n*pn + (b x n)*paan
  logic                 f1_v_r;
  logic signed [TW-1:0] f1_p_r [2][3][3];
  frd_pkg::in_t         f1_item_r;
  logic                 f1_deg_r;
  frd_pkg::word_t       rv [2][3];
  logic                 out_valid_r;
  frd_pkg::out_t        out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f1_v_r      <= d2_v_r;
      out_valid_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 2; w++) begin
      for (int c = 0; c < 3; c++) begin
        f1_p_r[w][c][0] <= TW'(d2_b_r[c])  * TW'(d2_pr_r[w][0]);
        f1_p_r[w][c][1] <= TW'(d2_n_r[c])  * TW'(d2_pr_r[w][1]);
        f1_p_r[w][c][2] <= TW'(d2_bn_r[c]) * TW'(d2_pr_r[w][2]);
      end
    end
    f1_item_r <= d2_item_r;
    f1_deg_r  <= d2_deg_r;
  end

  always_comb begin
    for (int w = 0; w < 2; w++) begin
      for (int c = 0; c < 3; c++) begin
        rv[w][c] = frd_pkg::sat_word(frd_pkg::rnd_shr(RW'(f1_p_r[w][c][0])
                   + RW'(f1_p_r[w][c][1]) + RW'(f1_p_r[w][c][2])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_deg_r) begin
      out_item_r.out_u_x    <= f1_item_r.frame_u_x;
      out_item_r.out_u_y    <= f1_item_r.frame_u_y;
      out_item_r.out_u_z    <= f1_item_r.frame_u_z;
      out_item_r.out_v_x    <= f1_item_r.frame_v_x;
      out_item_r.out_v_y    <= f1_item_r.frame_v_y;
      out_item_r.out_v_z    <= f1_item_r.frame_v_z;
      out_item_r.out_from_x <= f1_item_r.from_dir_x;
      out_item_r.out_from_y <= f1_item_r.from_dir_y;
      out_item_r.out_from_z <= f1_item_r.from_dir_z;
      out_item_r.rotated    <= 1'b0;
    end else begin
      out_item_r.out_u_x    <= rv[0][0];
      out_item_r.out_u_y    <= rv[0][1];
      out_item_r.out_u_z    <= rv[0][2];
      out_item_r.out_v_x    <= rv[1][0];
      out_item_r.out_v_y    <= rv[1][1];
      out_item_r.out_v_z    <= rv[1][2];
      out_item_r.out_from_x <= f1_item_r.to_dir_x;
      out_item_r.out_from_y <= f1_item_r.to_dir_y;
      out_item_r.out_from_z <= f1_item_r.to_dir_z;
      out_item_r.rotated    <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/frd_checker.sv */
`include "frame_rotate_to_direction_core_macros.svh"

module frd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input frd_pkg::in_t  in_item,
  input logic          out_valid,
  input frd_pkg::out_t out_item
);

  localparam int LAT = frd_pkg::PIPE_LAT;

  property p_pass_through;
    (out_valid && !out_item.rotated) |->
      ((out_item.out_u_x == $past(in_item.frame_u_x, LAT)) &&
       (out_item.out_v_z == $past(in_item.frame_v_z, LAT)) &&
       (out_item.out_from_x == $past(in_item.from_dir_x, LAT)));
  endproperty

  property p_new_source;
    (out_valid && out_item.rotated) |->
      ((out_item.out_from_x == $past(in_item.to_dir_x, LAT)) &&
       (out_item.out_from_y == $past(in_item.to_dir_y, LAT)) &&
       (out_item.out_from_z == $past(in_item.to_dir_z, LAT)));
  endproperty

  `FRD_ASSERT_CLK(a_busy_after_rst, !rst_n |=> busy, "busy not raised by reset")
  `FRD_ASSERT_CLK(a_no_orphan, out_valid |-> $past(start && !busy, LAT), "result without beat")
  `FRD_ASSERT_RST(a_pass_through, p_pass_through, "pass-through mismatch")
  `FRD_ASSERT_RST(a_new_source, p_new_source, "new source is not target")

endmodule

bind frame_rotate_to_direction_core frd_checker u_frd_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int PIPE_CYCLES = 150;
  localparam int STALL_LIMIT = 5000;
  localparam longint AXIS_MIN_SQ = ((64'sd1 << 60) / 100) * 81;
  localparam frd_pkg::word_t W_MAX = 32'sh7fffffff;
  localparam frd_pkg::word_t W_MIN = 32'sh80000000;

  typedef longint vec3_t [3];

  typedef struct {
    frd_pkg::in_t  item;
    bit            typed;
    frd_pkg::out_t want;
  } dir_row_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  frd_pkg::in_t   in_item;
  logic           out_valid;
  frd_pkg::out_t  out_item;

  frd_pkg::out_t  expect_q [$];
  int    n_errors;
  int    n_rotated;
  int    n_passed;
  int    stall_cnt;

  frame_rotate_to_direction_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic logic [63:0] mag_of(longint v);
    mag_of = (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round half away from zero, dropping 30 fraction bits.
  function automatic longint round_q30(longint v);
    logic [63:0] m;
    m = (mag_of(v) + (64'd1 << 29)) >> 30;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void to_unit(input vec3_t v, output vec3_t u);
    logic [63:0] m [3];
    logic [63:0] top;
    logic [63:0] sq;
    logic [63:0] nrm;
    logic [63:0] q;
    for (int i = 0; i < 3; i++) m[i] = mag_of(v[i]);
    top = (m[0] > m[1]) ? m[0] : m[1];
    top = (top > m[2]) ? top : m[2];
    if (top == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (top >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      top = top >> 1;
    end
    while (top < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      top = top << 1;
    end
    sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    nrm = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (nrm >> 1)) / nrm;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross3(input vec3_t p, input vec3_t q, output vec3_t r);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic frd_pkg::word_t sat_shift(longint r, int e);
    logic [63:0] m;
    logic [63:0] lim;
    m = mag_of(r);
    lim = (r < 0) ? 64'h80000000 : 64'h7fffffff;
    if (m > (lim >> e)) m = lim;
    else m = m << e;
    return (r < 0) ? frd_pkg::word_t'(-m) : frd_pkg::word_t'(m);
  endfunction

  function automatic void turn_vec(input frd_pkg::word_t raw [3], input vec3_t ua,
                                   input vec3_t ub, input vec3_t ax, input vec3_t a_ax,
                                   input vec3_t b_ax, output frd_pkg::word_t res [3]);
    vec3_t x;
    logic [63:0] m [3];
    logic [63:0] top;
    longint pa, pn, paan;
    int e;
    e = 0;
    for (int i = 0; i < 3; i++) m[i] = mag_of(longint'(raw[i]));
    top = (m[0] > m[1]) ? m[0] : m[1];
    top = (top > m[2]) ? top : m[2];
    while (top > (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      top = top >> 1;
      e++;
    end
    for (int i = 0; i < 3; i++) x[i] = (raw[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
    pa   = round_q30(x[0] * ua[0] + x[1] * ua[1] + x[2] * ua[2]);
    pn   = round_q30(x[0] * ax[0] + x[1] * ax[1] + x[2] * ax[2]);
    paan = round_q30(x[0] * a_ax[0] + x[1] * a_ax[1] + x[2] * a_ax[2]);
    for (int i = 0; i < 3; i++)
      res[i] = sat_shift(round_q30(ub[i] * pa + ax[i] * pn + b_ax[i] * paan), e);
  endfunction

  function automatic frd_pkg::out_t predict_frame(frd_pkg::in_t it);
    vec3_t ra, rb, ua, ub, c, ax, a_ax, b_ax;
    frd_pkg::word_t u_in [3];
    frd_pkg::word_t v_in [3];
    frd_pkg::word_t u_res [3];
    frd_pkg::word_t v_res [3];
    longint len_sq;
    frd_pkg::out_t o;
    ra = '{it.from_dir_x, it.from_dir_y, it.from_dir_z};
    rb = '{it.to_dir_x, it.to_dir_y, it.to_dir_z};
    u_in = '{it.frame_u_x, it.frame_u_y, it.frame_u_z};
    v_in = '{it.frame_v_x, it.frame_v_y, it.frame_v_z};
    to_unit(ra, ua);
    to_unit(rb, ub);
    cross3(ua, ub, c);
    to_unit(c, ax);
    len_sq = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
    if (len_sq < AXIS_MIN_SQ) begin
      o = '{it.frame_u_x, it.frame_u_y, it.frame_u_z, it.frame_v_x, it.frame_v_y,
            it.frame_v_z, it.from_dir_x, it.from_dir_y, it.from_dir_z, 1'b0};
      return o;
    end
    cross3(ua, ax, c);
    for (int i = 0; i < 3; i++) a_ax[i] = round_q30(c[i]);
    cross3(ub, ax, c);
    for (int i = 0; i < 3; i++) b_ax[i] = round_q30(c[i]);
    turn_vec(u_in, ua, ub, ax, a_ax, b_ax, u_res);
    turn_vec(v_in, ua, ub, ax, a_ax, b_ax, v_res);
    o = '{u_res[0], u_res[1], u_res[2], v_res[0], v_res[1], v_res[2],
          it.to_dir_x, it.to_dir_y, it.to_dir_z, 1'b1};
    return o;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string fld, frd_pkg::word_t got, frd_pkg::word_t want);
    $display("mismatch %s: got %0d want %0d at %0t", fld, got, want, $realtime);
    n_errors++;
  endtask

  task automatic check_word(string fld, frd_pkg::word_t got, frd_pkg::word_t want);
    if (got !== want) report_mismatch(fld, got, want);
  endtask

  always @(posedge clk) begin
    frd_pkg::out_t w;
    if (rst_n && out_valid) begin
      if (expect_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        n_errors++;
      end else begin
        w = expect_q.pop_front();
        check_word("out_u_x", out_item.out_u_x, w.out_u_x);
        check_word("out_u_y", out_item.out_u_y, w.out_u_y);
        check_word("out_u_z", out_item.out_u_z, w.out_u_z);
        check_word("out_v_x", out_item.out_v_x, w.out_v_x);
        check_word("out_v_y", out_item.out_v_y, w.out_v_y);
        check_word("out_v_z", out_item.out_v_z, w.out_v_z);
        check_word("out_from_x", out_item.out_from_x, w.out_from_x);
        check_word("out_from_y", out_item.out_from_y, w.out_from_y);
        check_word("out_from_z", out_item.out_from_z, w.out_from_z);
        check_word("rotated", frd_pkg::word_t'(out_item.rotated),
                   frd_pkg::word_t'(w.rotated));
        if (w.rotated) n_rotated++;
        else n_passed++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_beat(frd_pkg::in_t it, bit typed, frd_pkg::out_t want);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expect_q.push_back(typed ? want : predict_frame(it));
  endtask

  // each cycle before the next beat stays idle with the given chance
  task automatic maybe_idle(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic frd_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return W_MAX;
          1: return W_MIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      1, 2, 3: return frd_pkg::word_t'($urandom);
      4: return frd_pkg::word_t'($signed($urandom_range(0, 255)) - 128);
      default: return frd_pkg::word_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic frd_pkg::in_t rand_frame();
    frd_pkg::in_t it;
    it = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    // Force a degenerate axis now and then.
    case ($urandom_range(0, 19))
      0: {it.to_dir_x, it.to_dir_y, it.to_dir_z} = {it.from_dir_x, it.from_dir_y, it.from_dir_z};
      1: {it.to_dir_x, it.to_dir_y, it.to_dir_z} =
           {-it.from_dir_x, -it.from_dir_y, -it.from_dir_z};
      2: {it.from_dir_x, it.from_dir_y, it.from_dir_z} = '0;
      3: {it.to_dir_x, it.to_dir_y, it.to_dir_z} = '0;
      default: ;
    endcase
    return it;
  endfunction

  function automatic frd_pkg::out_t echo_of(frd_pkg::in_t it);
    return '{it.frame_u_x, it.frame_u_y, it.frame_u_z, it.frame_v_x, it.frame_v_y,
             it.frame_v_z, it.from_dir_x, it.from_dir_y, it.from_dir_z, 1'b0};
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    frd_pkg::in_t it;
    int idle_pct;

    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    n_errors = 0;
    n_rotated = 0;
    n_passed = 0;
    stall_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // zero source, extremes in the frame
    it = '{0, 0, 0, 32'sh10000, 0, 0, W_MAX, W_MIN, 0, -1, 1, W_MAX};
    rows.push_back('{it, 1'b1, echo_of(it)});
    // zero target
    it = '{W_MIN, W_MAX, 7, 0, 0, 0, 5, -5, W_MIN, W_MAX, W_MAX, W_MIN};
    rows.push_back('{it, 1'b1, echo_of(it)});
    // all zero
    it = '0;
    rows.push_back('{it, 1'b1, echo_of(it)});
    // parallel: equal directions
    it = '{32'sh10000, 32'sh20000, -32'sh30000, 32'sh10000, 32'sh20000, -32'sh30000,
           123, -456, 789, W_MIN, W_MIN, W_MIN};
    rows.push_back('{it, 1'b1, echo_of(it)});
    // parallel with different length
    it = '{1, 2, 3, 32'sh10000, 32'sh20000, 32'sh30000, W_MAX, W_MAX, W_MAX, 0, 0, 0};
    rows.push_back('{it, 1'b1, echo_of(it)});
    // antiparallel
    it = '{W_MAX, 0, 0, W_MIN, 0, 0, 1, 2, 3, 4, 5, 6};
    rows.push_back('{it, 1'b1, echo_of(it)});
    it = '{-5, 9, -13, 5, -9, 13, -1, -1, -1, 32'sh10000, 0, 0};
    rows.push_back('{it, 1'b1, echo_of(it)});
    // quarter turns about each axis
    it = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000};
    rows.push_back('{it, 1'b0, '0});
    it = '{0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 0, 0};
    rows.push_back('{it, 1'b0, '0});
    it = '{0, 0, 1, 1, 0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0};
    rows.push_back('{it, 1'b0, '0});
    // saturation: extreme frames under a rotation
    it = '{W_MAX, 0, 0, 0, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN};
    rows.push_back('{it, 1'b0, '0});
    it = '{W_MIN, W_MIN, 0, 0, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX};
    rows.push_back('{it, 1'b0, '0});
    // extreme directions, tiny frame
    it = '{W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, 1, 1, -1, 0, 0, 1, -1};
    rows.push_back('{it, 1'b0, '0});
    // nearly parallel
    it = '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX - 1, 32'sh10000, 32'sh10000, 0,
           0, -32'sh10000, 32'sh10000};
    rows.push_back('{it, 1'b0, '0});
    it = '{1, 0, 0, 1000000, 1, 0, 32'sh7000000, -32'sh7000000, 3, 3, 3, 3};
    rows.push_back('{it, 1'b0, '0});

    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.item, row.typed, row.want);
      maybe_idle(20);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 25 : (ph == 1) ? 65 : 0;
      for (int n = 0; n < 230; n++) begin
        send_beat(rand_frame(), 1'b0, '0);
        if (n == 115) drain_results();
        else maybe_idle(idle_pct);
      end
    end

    drain_results();
    repeat (PIPE_CYCLES + 10) @(posedge clk);
    $display("covered %0d rotated and %0d pass-through results", n_rotated, n_passed);
    $display("sender idling at 25%% and 65%% and back to back, with full drains between");
    if (n_errors == 0 && expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expect_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
